// File: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the token decoder.
// Standalone header; the assertions vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every clock edge outside reset.
`define CFF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define CFF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFF_ASSERT(lbl, clk, rst_n, prop, msg)
`define CFF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hw/rtl/cffdtd_pkg.sv
// Types and constants of the CFF DICT / Type 2 token decoder.
// No dependencies; used by the channel interfaces and the core.
package cffdtd_pkg;

  localparam logic [5:0] MaxOperands = 6'd48;

  localparam logic [7:0] ByteEscape    = 8'd12;
  localparam logic [7:0] ByteShortInt  = 8'd28;
  localparam logic [7:0] ByteDictLong  = 8'd29;
  localparam logic [7:0] ByteDictReal  = 8'd30;
  localparam logic [7:0] ByteT2Long    = 8'd255;
  localparam logic [7:0] ByteDictOpMax = 8'd21;
  localparam logic [7:0] ByteOpLimit   = 8'd31;
  localparam logic [7:0] ByteSmallMin  = 8'd32;
  localparam logic [7:0] ByteSmallMax  = 8'd246;
  localparam logic [7:0] BytePosMin    = 8'd247;
  localparam logic [7:0] BytePosMax    = 8'd250;
  localparam logic [7:0] ByteNegMin    = 8'd251;
  localparam logic [7:0] ByteNegMax    = 8'd254;
  localparam logic [8:0] SmallBias     = 9'd139;
  localparam logic [10:0] TwoByteBias  = 11'd108;

  typedef enum logic [1:0] {
    ErrNone     = 2'd0,
    ErrReserved = 2'd1,
    ErrReal     = 2'd2,
    ErrOverflow = 2'd3
  } err_e;

  typedef enum logic {
    KindOperand  = 1'b0,
    KindOperator = 1'b1
  } kind_e;

  typedef enum logic {
    DialectDict  = 1'b0,
    DialectType2 = 1'b1
  } dialect_e;

endpackage

// File: hw/rtl/cffdtd_ifs.sv
// Valid/ready channel interfaces of the token decoder: byte input and token output.
// Depends on cffdtd_pkg for the payload types.
interface cffdtd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface cffdtd_tok_if import cffdtd_pkg::*; ();
  logic               valid;
  logic               ready;
  kind_e              token_kind;
  logic               escaped;
  logic signed [31:0] token_value;
  logic [2:0]         byte_length;
  logic [5:0]         operand_count;
  err_e               error_code;

  modport source (output valid, output token_kind, output escaped, output token_value,
                  output byte_length, output operand_count, output error_code,
                  input ready);
  modport sink   (input valid, input token_kind, input escaped, input token_value,
                  input byte_length, input operand_count, input error_code,
                  output ready);
endinterface

// File: hw/rtl/cff_dict_token_decoder_core.sv
// Core of the CFF DICT / Type 2 charstring token decoder; depends on cffdtd_pkg,
// the cffdtd_byte_if / cffdtd_tok_if interfaces and assert_macros.svh.
// The last byte of a token is captured in the byte register and decoded from there into
// the result register, which drives the token output.
// Throughput: one byte per cycle while the token sink keeps up; a stalled result holds one byte.
// Reset: asynchronous, active low; clears token state, operand count, dialect and valids.
`include "assert_macros.svh"

module cff_dict_token_decoder_core import cffdtd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  cffdtd_byte_if.sink  byte_i,
  cffdtd_tok_if.source tok_o
);

  // Dialect register. The user must write it only while the decoder is idle, so that it
  // is consistent with the lead byte that samples it; the block does not enforce this.
  dialect_e dialect_q;

  // Byte register: the front stage that parts the input handshake from decoding.
  logic       bvalid_q;
  logic [7:0] byte_q;

  // Token assembly state. rem_q counts the continuation bytes still to come;
  // zero means the next byte is a lead byte.
  logic [2:0]  rem_q, rem_d;
  logic [7:0]  lead_q, lead_d;
  logic [31:0] acc_q, acc_d;
  logic [5:0]  cnt_q, cnt_d;

  // Result register.
  logic               ovalid_q;
  kind_e              kind_q;
  logic               esc_q;
  logic signed [31:0] val_q;
  logic [2:0]         len_q;
  logic [5:0]         ocnt_q;
  err_e               err_q;

  // Decode results for the byte in the byte register.
  logic        emit;
  logic        is_opnd;
  kind_e       r_kind;
  logic        r_esc;
  logic [31:0] r_val;
  logic [2:0]  r_len;
  logic [5:0]  r_cnt;
  err_e        r_err;

  logic [31:0] acc_sh;
  logic [2:0]  rem_dec;
  logic [7:0]  lead_pos_off, lead_neg_off;
  logic [10:0] pos_mag, neg_mag;
  logic [8:0]  small_val;

  logic advance;

  always_comb begin
    acc_sh       = {acc_q[23:0], byte_q};
    rem_dec      = rem_q - 3'd1;
    lead_pos_off = lead_q - BytePosMin;
    lead_neg_off = lead_q - ByteNegMin;
    pos_mag      = {1'b0, lead_pos_off[1:0], acc_sh[7:0]} + TwoByteBias;
    neg_mag      = {1'b0, lead_neg_off[1:0], acc_sh[7:0]} + TwoByteBias;
    small_val    = {1'b0, byte_q} - SmallBias;

    rem_d   = rem_q;
    lead_d  = lead_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    emit    = 1'b0;
    is_opnd = 1'b0;
    r_kind  = KindOperand;
    r_esc   = 1'b0;
    r_val   = '0;
    r_len   = 3'd1;
    r_cnt   = '0;
    r_err   = ErrNone;

    if (rem_q != 3'd0) begin
      // Continuation byte: shift it in; the token finishes on the last one.
      acc_d = acc_sh;
      rem_d = rem_dec;
      if (rem_dec == 3'd0) begin
        emit = 1'b1;
        if (lead_q == ByteEscape) begin
          r_kind = KindOperator;
          r_esc  = 1'b1;
          r_val  = {24'd0, acc_sh[7:0]};
          r_len  = 3'd2;
          r_cnt  = cnt_q;
          cnt_d  = '0;
        end else if (lead_q == ByteShortInt) begin
          is_opnd = 1'b1;
          r_val   = {{16{acc_sh[15]}}, acc_sh[15:0]};
          r_len   = 3'd3;
        end else if (lead_q == ByteDictLong || lead_q == ByteT2Long) begin
          is_opnd = 1'b1;
          r_val   = acc_sh;
          r_len   = 3'd5;
        end else if (lead_q >= BytePosMin && lead_q <= BytePosMax) begin
          is_opnd = 1'b1;
          r_val   = {21'd0, pos_mag};
          r_len   = 3'd2;
        end else begin
          // Negative two-byte form, leads 251 through 254.
          is_opnd = 1'b1;
          r_val   = 32'd0 - {21'd0, neg_mag};
          r_len   = 3'd2;
        end
      end
    end else if (byte_q == ByteEscape) begin
      lead_d = byte_q;
      rem_d  = 3'd1;
      acc_d  = '0;
    end else if (byte_q == ByteShortInt) begin
      lead_d = byte_q;
      rem_d  = 3'd2;
      acc_d  = '0;
    end else if (byte_q >= ByteSmallMin && byte_q <= ByteSmallMax) begin
      emit    = 1'b1;
      is_opnd = 1'b1;
      r_val   = {{23{small_val[8]}}, small_val};
    end else if (byte_q >= BytePosMin && byte_q <= ByteNegMax) begin
      lead_d = byte_q;
      rem_d  = 3'd1;
      acc_d  = '0;
    end else if (dialect_q == DialectDict) begin
      if (byte_q <= ByteDictOpMax) begin
        emit   = 1'b1;
        r_kind = KindOperator;
        r_val  = {24'd0, byte_q};
        r_cnt  = cnt_q;
        cnt_d  = '0;
      end else if (byte_q == ByteDictLong) begin
        lead_d = byte_q;
        rem_d  = 3'd4;
        acc_d  = '0;
      end else begin
        // A real number is reported but its nibbles are not consumed; any other
        // byte here is reserved. Both clear the operand count.
        emit  = 1'b1;
        r_val = {24'd0, byte_q};
        r_err = (byte_q == ByteDictReal) ? ErrReal : ErrReserved;
        cnt_d = '0;
      end
    end else if (byte_q == ByteT2Long) begin
      lead_d = byte_q;
      rem_d  = 3'd4;
      acc_d  = '0;
    end else begin
      // Type 2: every remaining byte below 32 is a plain operator.
      emit   = 1'b1;
      r_kind = KindOperator;
      r_val  = {24'd0, byte_q};
      r_cnt  = cnt_q;
      cnt_d  = '0;
    end

    // Operand counting: once the stack is full, further operands are flagged
    // and not counted.
    if (is_opnd) begin
      if (cnt_q >= MaxOperands) begin
        r_err = ErrOverflow;
        cnt_d = MaxOperands;
      end else begin
        cnt_d = cnt_q + 6'd1;
      end
    end
  end

  // A byte leaves the byte register when it causes no result, or when the
  // result register is empty or being drained in this cycle.
  assign advance     = bvalid_q && (!emit || !ovalid_q || tok_o.ready);
  assign byte_i.ready = !bvalid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dialect_q <= DialectDict;
    end else if (cfg_we_i) begin
      dialect_q <= dialect_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
    end else if (byte_i.ready) begin
      bvalid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      byte_q <= byte_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      lead_q <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
    end else if (advance) begin
      rem_q  <= rem_d;
      lead_q <= lead_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (advance && emit) begin
      ovalid_q <= 1'b1;
    end else if (tok_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      kind_q <= r_kind;
      esc_q  <= r_esc;
      val_q  <= r_val;
      len_q  <= r_len;
      ocnt_q <= r_cnt;
      err_q  <= r_err;
    end
  end

  assign tok_o.valid         = ovalid_q;
  assign tok_o.token_kind    = kind_q;
  assign tok_o.escaped       = esc_q;
  assign tok_o.token_value   = val_q;
  assign tok_o.byte_length   = len_q;
  assign tok_o.operand_count = ocnt_q;
  assign tok_o.error_code    = err_q;

  // The operand count saturates at the stack limit.
  `CFF_ASSERT(a_cnt_limit, clk_i, rst_ni, cnt_q <= MaxOperands, "operand count above limit")
  // Four continuation bytes only follow a 32-bit operand lead.
  `CFF_ASSERT(a_long_lead, clk_i, rst_ni,
              (rem_q == 3'd4) |-> (lead_q == ByteDictLong || lead_q == ByteT2Long),
              "long form with wrong lead")
  // Every error result is reported with the operand kind.
  `CFF_ASSERT(a_err_kind, clk_i, rst_ni,
              (ovalid_q && err_q != ErrNone) |-> (kind_q == KindOperand),
              "error result marked as operator")
  // An escaped operator spans two bytes; a plain one spans one.
  `CFF_ASSERT(a_op_len, clk_i, rst_ni,
              (ovalid_q && kind_q == KindOperator) |-> (len_q == (esc_q ? 3'd2 : 3'd1)),
              "operator length mismatch")
  // A waiting result is never overwritten while the sink stalls.
  `CFF_ASSERT_ALWAYS(a_no_overwrite, clk_i,
                     (rst_ni && ovalid_q && !tok_o.ready) |-> !(advance && emit),
                     "pending result overwritten")

endmodule

// File: tb/cff_dict_token_decoder_core_test.sv
// Self-checking testbench of the CFF DICT / Type 2 token decoder core.
// Depends on cffdtd_pkg, the cffdtd_byte_if / cffdtd_tok_if interfaces and the core itself.
module cff_dict_token_decoder_core_test;
  import cffdtd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One decoded token as it appears on the output channel.
  typedef struct packed {
    kind_e              token_kind;
    logic               escaped;
    logic signed [31:0] token_value;
    logic [2:0]         byte_length;
    logic [5:0]         operand_count;
    err_e               error_code;
  } tok_t;

  // A stream byte waiting to be sent. When the token it completes has a result
  // that is obvious by inspection, that result is carried along and checked
  // instead of the one the decoder model works out.
  typedef struct {
    logic [7:0] data_byte;
    bit         typed;
    tok_t       want;
  } byte_item_t;

  typedef enum logic {
    RowByte,
    RowDialect
  } row_kind_e;

  typedef struct {
    row_kind_e  kind;
    byte_item_t item;
    dialect_e   dialect;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic cfg_wdata;

  cffdtd_byte_if byte_ch ();
  cffdtd_tok_if  tok_ch ();

  cff_dict_token_decoder_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .byte_i      (byte_ch),
    .tok_o       (tok_ch)
  );

  always #5 clk = ~clk;

  // Decoder model state: bytes still owed to an open token, its lead byte, the
  // continuation bytes gathered so far, the operands seen since the last operator,
  // and our copy of the dialect register.
  logic [2:0]  tail_left = 3'd0;
  logic [7:0]  tok_lead = 8'd0;
  logic [31:0] tok_acc = 32'd0;
  logic [5:0]  opnd_cnt = 6'd0;
  dialect_e    cfg_dialect = DialectDict;

  byte_item_t send_q[$];
  tok_t       due_tokens[$];
  byte_item_t on_wire;
  tok_t       predicted;

  int n_pushed = 0;
  int n_accepted = 0;
  int n_fail = 0;
  int n_tokens = 0;
  int n_operators = 0;
  int n_escaped = 0;
  int n_overflow = 0;
  int n_bad_byte = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_asked = 0;
  int hold_done = 0;
  int hold_left = 0;

  function automatic tok_t opnd(logic signed [31:0] v, logic [2:0] n, err_e e);
    return '{KindOperand, 1'b0, v, n, 6'd0, e};
  endfunction

  function automatic tok_t oper(logic esc, logic [7:0] code, logic [2:0] n, logic [5:0] cnt);
    return '{KindOperator, esc, {24'd0, code}, n, cnt, ErrNone};
  endfunction

  // An operand that arrives with the count already full is flagged and not counted.
  function automatic tok_t operand_tok(logic [31:0] v, logic [2:0] n);
    if (opnd_cnt >= MaxOperands) return opnd(v, n, ErrOverflow);
    opnd_cnt++;
    return opnd(v, n, ErrNone);
  endfunction

  // An operator reports the operands gathered for it and starts a fresh count.
  function automatic tok_t operator_tok(logic esc, logic [7:0] code, logic [2:0] n);
    tok_t t;
    t = oper(esc, code, n, opnd_cnt);
    opnd_cnt = 6'd0;
    return t;
  endfunction

  // A reserved byte or a DICT real also wipes the operand count.
  function automatic tok_t error_tok(logic [7:0] b, err_e e);
    opnd_cnt = 6'd0;
    return opnd({24'd0, b}, 3'd1, e);
  endfunction

  function automatic void open_token(logic [7:0] b, logic [2:0] n);
    tok_lead = b;
    tail_left = n;
    tok_acc = 32'd0;
  endfunction

  // Takes one accepted byte; returns 1 and the token when the byte completes one.
  function automatic bit decode_byte(input logic [7:0] b, output tok_t t);
    logic [7:0]  lo;
    logic [31:0] mag;
    t = '0;
    if (tail_left != 3'd0) begin
      tok_acc = {tok_acc[23:0], b};
      tail_left--;
      if (tail_left != 3'd0) return 1'b0;
      lo = tok_acc[7:0];
      if (tok_lead == ByteEscape) begin
        t = operator_tok(1'b1, lo, 3'd2);
      end else if (tok_lead == ByteShortInt) begin
        t = operand_tok({{16{tok_acc[15]}}, tok_acc[15:0]}, 3'd3);
      end else if (tok_lead == ByteDictLong || tok_lead == ByteT2Long) begin
        t = operand_tok(tok_acc, 3'd5);
      end else if (tok_lead <= BytePosMax) begin
        mag = ({24'd0, tok_lead - BytePosMin} << 8) + {24'd0, lo} + {21'd0, TwoByteBias};
        t = operand_tok(mag, 3'd2);
      end else begin
        mag = ({24'd0, tok_lead - ByteNegMin} << 8) + {24'd0, lo} + {21'd0, TwoByteBias};
        t = operand_tok(32'd0 - mag, 3'd2);
      end
      return 1'b1;
    end
    // Lead byte: the forms shared by both dialects come first.
    if (b == ByteEscape) begin
      open_token(b, 3'd1);
      return 1'b0;
    end
    if (b == ByteShortInt) begin
      open_token(b, 3'd2);
      return 1'b0;
    end
    if (b >= ByteSmallMin && b <= ByteSmallMax) begin
      t = operand_tok({24'd0, b} - {23'd0, SmallBias}, 3'd1);
      return 1'b1;
    end
    if (b >= BytePosMin && b <= ByteNegMax) begin
      open_token(b, 3'd1);
      return 1'b0;
    end
    if (cfg_dialect == DialectDict) begin
      if (b <= ByteDictOpMax) begin
        t = operator_tok(1'b0, b, 3'd1);
      end else if (b == ByteDictLong) begin
        open_token(b, 3'd4);
        return 1'b0;
      end else if (b == ByteDictReal) begin
        t = error_tok(b, ErrReal);
      end else begin
        t = error_tok(b, ErrReserved);
      end
      return 1'b1;
    end
    if (b == ByteT2Long) begin
      open_token(b, 3'd4);
      return 1'b0;
    end
    t = operator_tok(1'b0, b, 3'd1);
    return 1'b1;
  endfunction

  // Byte sender. A transfer at this edge is run through the decoder model first;
  // then the next byte is offered, unless the sender decides to idle this cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (byte_ch.valid && byte_ch.ready) begin
        if (decode_byte(on_wire.data_byte, predicted)) begin
          due_tokens.push_back(on_wire.typed ? on_wire.want : predicted);
        end
        n_accepted++;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (send_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          on_wire = send_q.pop_front();
          byte_ch.valid <= 1'b1;
          byte_ch.data_byte <= on_wire.data_byte;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Token receiver. Every transfer is checked against the oldest token still due.
  // A hold-off request makes it refuse tokens for a long stretch, counted here.
  always @(posedge clk) begin
    tok_t want;
    if (rst_n) begin
      if (tok_ch.valid && tok_ch.ready) begin
        n_tokens++;
        if (tok_ch.token_kind === KindOperator) n_operators++;
        if (tok_ch.escaped === 1'b1) n_escaped++;
        if (tok_ch.error_code === ErrOverflow) n_overflow++;
        if (tok_ch.error_code === ErrReserved || tok_ch.error_code === ErrReal) n_bad_byte++;
        if (due_tokens.size() == 0) begin
          $error("token transfer with nothing due: value %0d", tok_ch.token_value);
          n_fail++;
        end else begin
          want = due_tokens.pop_front();
          if (tok_ch.token_kind !== want.token_kind) begin
            $error("token_kind: expected %0d, got %0d", want.token_kind, tok_ch.token_kind);
            n_fail++;
          end
          if (tok_ch.escaped !== want.escaped) begin
            $error("escaped: expected %0d, got %0d", want.escaped, tok_ch.escaped);
            n_fail++;
          end
          if (tok_ch.token_value !== want.token_value) begin
            $error("token_value: expected %0d, got %0d", want.token_value, tok_ch.token_value);
            n_fail++;
          end
          if (tok_ch.byte_length !== want.byte_length) begin
            $error("byte_length: expected %0d, got %0d", want.byte_length, tok_ch.byte_length);
            n_fail++;
          end
          if (tok_ch.operand_count !== want.operand_count) begin
            $error("operand_count: expected %0d, got %0d",
                   want.operand_count, tok_ch.operand_count);
            n_fail++;
          end
          if (tok_ch.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, tok_ch.error_code);
            n_fail++;
          end
        end
      end
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        tok_ch.ready <= 1'b0;
      end else begin
        tok_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  function automatic stim_row_t raw(logic [7:0] d);
    return '{RowByte, '{d, 1'b0, '0}, DialectDict};
  endfunction

  function automatic stim_row_t chk(logic [7:0] d, tok_t e);
    return '{RowByte, '{d, 1'b1, e}, DialectDict};
  endfunction

  function automatic stim_row_t dia(dialect_e d);
    return '{RowDialect, '{8'd0, 1'b0, '0}, d};
  endfunction

  task automatic push_byte(logic [7:0] d);
    send_q.push_back('{d, 1'b0, '0});
    n_pushed++;
  endtask

  // Waits until every byte has been taken and every token has come back, then
  // lets the pipeline run on so that the last byte taken has been decoded.
  task automatic settle();
    while (n_accepted != n_pushed || due_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dialect(dialect_e d);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    cfg_dialect = d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One operand in any of the number forms of the current dialect.
  task automatic push_operand();
    case ($urandom_range(0, 4))
      0: push_byte(8'($urandom_range(32, 246)));
      1: begin
        push_byte(8'($urandom_range(247, 250)));
        push_byte(8'($urandom_range(0, 255)));
      end
      2: begin
        push_byte(8'($urandom_range(251, 254)));
        push_byte(8'($urandom_range(0, 255)));
      end
      3: begin
        push_byte(ByteShortInt);
        repeat (2) push_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        push_byte(cfg_dialect == DialectDict ? ByteDictLong : ByteT2Long);
        repeat (4) push_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic push_operator();
    logic [7:0] code;
    if ($urandom_range(0, 4) == 0) begin
      push_byte(ByteEscape);
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      do begin
        if (cfg_dialect == DialectDict) code = 8'($urandom_range(0, 21));
        else code = 8'($urandom_range(0, 31));
      end while (code == ByteEscape || (cfg_dialect == DialectType2 && code == ByteShortInt));
      push_byte(code);
    end
  endtask

  // Mostly well-formed operand lists closed by an operator; a tenth of them hold 46 to
  // 60 operands, enough for most to run past the operand limit. The rest is raw noise,
  // bytes the DICT form rejects, and multi-byte tokens cut short by whatever follows.
  task automatic push_group();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(46, 60) : $urandom_range(0, 6))
        push_operand();
      push_operator();
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 93) begin
      case ($urandom_range(0, 3))
        0: push_byte(8'($urandom_range(22, 27)));
        1: push_byte(ByteDictReal);
        2: push_byte(ByteOpLimit);
        default: push_byte(ByteT2Long);
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: push_byte(ByteEscape);
        1: push_byte(ByteShortInt);
        2: push_byte(ByteDictLong);
        default: push_byte(8'($urandom_range(247, 255)));
      endcase
    end
  endtask

  initial begin
    stim_row_t rows[$];
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = 8'd0;
    tok_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting from the reset dialect (DICT). Six operands of every
    // form with their extremes, then an operator that must report all six, an
    // escaped operator, the reserved and real-number bytes, and a Type 2 stretch
    // in which the dialect flips back to DICT while a 32-bit operand is open.
    rows = {
      chk(8'd139, opnd(32'sd0, 3'd1, ErrNone)),
      chk(8'd32, opnd(-32'sd107, 3'd1, ErrNone)),
      raw(8'd247), chk(8'd0, opnd(32'sd108, 3'd2, ErrNone)),
      raw(8'd254), raw(8'd255),
      raw(ByteShortInt), raw(8'h80), raw(8'h00),
      raw(ByteDictLong), raw(8'h7F), raw(8'hFF), raw(8'hFF),
      chk(8'hFF, opnd(32'sh7FFF_FFFF, 3'd5, ErrNone)),
      chk(8'd21, oper(1'b0, 8'd21, 3'd1, 6'd6)),
      raw(ByteEscape), chk(8'd35, oper(1'b1, 8'd35, 3'd2, 6'd0)),
      chk(8'd22, opnd(32'sd22, 3'd1, ErrReserved)),
      chk(ByteDictReal, opnd(32'sd30, 3'd1, ErrReal)),
      chk(8'd255, opnd(32'sd255, 3'd1, ErrReserved)),
      dia(DialectType2),
      chk(ByteDictLong, oper(1'b0, ByteDictLong, 3'd1, 6'd0)),
      raw(ByteT2Long),
      dia(DialectDict),
      raw(8'h80), raw(8'h00), raw(8'h00),
      chk(8'h00, opnd(32'sh8000_0000, 3'd5, ErrNone)),
      chk(8'd0, oper(1'b0, 8'd0, 3'd1, 6'd1))
    };
    src_idle_pct = 10;
    snk_idle_pct = 72;
    foreach (rows[i]) begin
      if (rows[i].kind == RowDialect) begin
        write_dialect(rows[i].dialect);
      end else begin
        send_q.push_back(rows[i].item);
        n_pushed++;
      end
    end

    // Random part: three idling patterns, each run under both dialects. The long
    // receiver hold-off lands where the sender never idles, so the core backs up.
    for (int mode = 0; mode < 3; mode++) begin
      for (int d = 0; d < 2; d++) begin
        int base;
        write_dialect(d == 0 ? DialectType2 : DialectDict);
        src_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 72 : 0;
        snk_idle_pct = (mode == 0) ? 72 : (mode == 1) ? 10 : 0;
        if (mode == 2 && d == 1) hold_asked++;
        base = n_pushed;
        while (n_pushed - base < 283) push_group();
      end
    end

    while (n_accepted != n_pushed || due_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes in both dialects; checked %0d tokens: %0d operators (%0d escaped),",
             n_accepted, n_tokens, n_operators, n_escaped);
    $display("%0d operand overflows, %0d reserved or real-number bytes.",
             n_overflow, n_bad_byte);
    if (n_fail == 0) begin
      $display("cff_dict_token_decoder_core_test: done, clean");
    end else begin
      $display("cff_dict_token_decoder_core_test: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #5ms;
    $display("timeout: %0d of %0d bytes taken, %0d tokens due",
             n_accepted, n_pushed, due_tokens.size());
    $display("cff_dict_token_decoder_core_test: done, errors");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/cffdtd_pkg.sv
hw/rtl/cffdtd_ifs.sv
hw/rtl/cff_dict_token_decoder_core.sv
tb/cff_dict_token_decoder_core_test.sv
